/* design/ptag_pkg.sv */
// Package for the projective texture address generator.
// Shared constants, register indexes, outcome codes, config and sideband structs.
// No dependencies.
package ptag_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF  = 20;
    localparam int COEF_W         = 32;
    localparam int OFF_W          = 24;
    localparam int DIM_W          = 16;
    localparam int QUO_BITS       = 16;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_COEF_A   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_B   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_C   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_D   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_L   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_SIZE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_CANVAS   = 3'd7;

    typedef enum logic [1:0] {
        OUT_WRITE   = 2'd0,
        OUT_OUTSIDE = 2'd1,
        OUT_CLIPPED = 2'd2,
        OUT_DEGEN   = 2'd3
    } ptag_outcome_t;

    typedef struct packed {
        logic [COEF_W-1:0] m00;
        logic [COEF_W-1:0] m01;
        logic [COEF_W-1:0] m02;
        logic [COEF_W-1:0] m10;
        logic [COEF_W-1:0] m11;
        logic [COEF_W-1:0] m12;
        logic [COEF_W-1:0] m20;
        logic [COEF_W-1:0] m21;
        logic [COEF_W-1:0] m22;
        logic [DIM_W-1:0]  src_w;
        logic [DIM_W-1:0]  src_h;
        logic [DIM_W-1:0]  clip_x1;
        logic [DIM_W-1:0]  clip_x2;
        logic [DIM_W-1:0]  clip_y1;
        logic [DIM_W-1:0]  clip_y2;
        logic              clip_en;
        logic              solid;
        logic              compressed;
        logic [DIM_W-1:0]  canvas_w;
        logic [DIM_W-1:0]  sec_y1;
        logic [DIM_W-1:0]  sec_x1;
    } ptag_cfg_t;

    // sideband that rides along with the divider
    typedef struct packed {
        logic             zero;
        logic             neg_x;
        logic             neg_y;
        logic [OFF_W-1:0] wr;
    } ptag_side_t;

endpackage

/* design/ptag_if.sv */
// Channel interfaces for the projective texture address generator.
// Depends on ptag_pkg.
interface ptag_in_if #(
    parameter int COORD_BITS = ptag_pkg::COORD_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] dst_x;
    logic [COORD_BITS-1:0] dst_y;

    modport source (output valid, output dst_x, output dst_y, input ready);
    modport sink   (input valid, input dst_x, input dst_y, output ready);
endinterface

interface ptag_out_if #(
    parameter int COORD_BITS = ptag_pkg::COORD_BITS_DEF
);
    logic                        valid;
    logic                        ready;
    logic [1:0]                  outcome;
    logic [COORD_BITS-1:0]       src_x;
    logic [COORD_BITS-1:0]       src_y;
    logic [ptag_pkg::OFF_W-1:0]  read_offset;
    logic [ptag_pkg::OFF_W-1:0]  write_offset;

    modport source (output valid, output outcome, output src_x, output src_y,
                    output read_offset, output write_offset, input ready);
    modport sink   (input valid, input outcome, input src_x, input src_y,
                    input read_offset, input write_offset, output ready);
endinterface

/* design/ptag_xform.sv */
// Homography front end: products, sums, then magnitude/sign prep for the divider.
// Three register stages. Depends on ptag_pkg.
module ptag_xform #(
    parameter int COORD_BITS = ptag_pkg::COORD_BITS_DEF,
    parameter int NUM_W      = ptag_pkg::COEF_W + ptag_pkg::COORD_BITS_DEF + 5
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  ptag_pkg::ptag_cfg_t   cfg,
    input  logic                  in_valid,
    input  logic [COORD_BITS-1:0] in_x,
    input  logic [COORD_BITS-1:0] in_y,
    output logic                  out_valid,
    output logic [NUM_W-1:0]      num_x,
    output logic [NUM_W-1:0]      num_y,
    output logic [NUM_W-1:0]      den,
    output ptag_pkg::ptag_side_t  side
);
    import ptag_pkg::*;

    localparam int PRW = COEF_W + COORD_BITS + 1;
    localparam int SW  = NUM_W - 2;

    function automatic logic signed [PRW-1:0] mul(input logic [COEF_W-1:0] m,
                                                  input logic signed [PRW-1:0] v);
        logic signed [PRW-1:0] ms;
        ms = PRW'($signed(m));
        return ms * v;
    endfunction

    logic signed [PRW-1:0] jx, iy;
    assign jx = $signed(PRW'({1'b0, in_x}));
    assign iy = $signed(PRW'({1'b0, in_y}));

    // stage 1
    logic                  v1_reg;
    logic signed [PRW-1:0] p00_reg, p01_reg, c02_reg;
    logic signed [PRW-1:0] p10_reg, p11_reg, c12_reg;
    logic signed [PRW-1:0] p20_reg, p21_reg, c22_reg;
    logic [OFF_W-1:0]      wdy_reg, wdx_reg;

    // stage 2
    logic                  v2_reg;
    logic signed [SW-1:0]  sx_reg, sy_reg, sz_reg;
    logic [OFF_W-1:0]      wr2_reg;

    // stage 3
    logic                  v3_reg;
    logic [NUM_W-1:0]      nx_reg, ny_reg, dn_reg;
    ptag_side_t            side_reg;

    logic signed [SW-1:0]  sx_next, sy_next, sz_next;
    logic [OFF_W+DIM_W-1:0] wprod;
    logic [SW-1:0]         ax, ay, az;

    assign sx_next = SW'(p00_reg) + SW'(p01_reg) + SW'(c02_reg);
    assign sy_next = SW'(p10_reg) + SW'(p11_reg) + SW'(c12_reg);
    assign sz_next = SW'(p20_reg) + SW'(p21_reg) + SW'(c22_reg);
    assign wprod   = wdy_reg * cfg.canvas_w;

    assign ax = sx_reg[SW-1] ? SW'(-sx_reg) : SW'(sx_reg);
    assign ay = sy_reg[SW-1] ? SW'(-sy_reg) : SW'(sy_reg);
    assign az = sz_reg[SW-1] ? SW'(-sz_reg) : SW'(sz_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p00_reg <= mul(cfg.m00, jx);
            p01_reg <= mul(cfg.m01, iy);
            c02_reg <= PRW'($signed(cfg.m02));
            p10_reg <= mul(cfg.m10, jx);
            p11_reg <= mul(cfg.m11, iy);
            c12_reg <= PRW'($signed(cfg.m12));
            p20_reg <= mul(cfg.m20, jx);
            p21_reg <= mul(cfg.m21, iy);
            c22_reg <= PRW'($signed(cfg.m22));
            wdy_reg <= OFF_W'(in_y) - OFF_W'(cfg.sec_y1);
            wdx_reg <= OFF_W'(in_x) - OFF_W'(cfg.sec_x1);

            sx_reg  <= sx_next;
            sy_reg  <= sy_next;
            sz_reg  <= sz_next;
            wr2_reg <= wprod[OFF_W-1:0] + wdx_reg;

            // round half away from zero: q = (2|a| + |b|) / (2|b|)
            nx_reg <= (NUM_W'(ax) << 1) + NUM_W'(az);
            ny_reg <= (NUM_W'(ay) << 1) + NUM_W'(az);
            dn_reg <= NUM_W'(az) << 1;
            side_reg.zero  <= (sz_reg == '0);
            side_reg.neg_x <= sx_reg[SW-1] ^ sz_reg[SW-1];
            side_reg.neg_y <= sy_reg[SW-1] ^ sz_reg[SW-1];
            side_reg.wr    <= wr2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign num_x     = nx_reg;
    assign num_y     = ny_reg;
    assign den       = dn_reg;
    assign side      = side_reg;

endmodule

/* design/ptag_div.sv */
// Pipelined restoring divider, two lanes sharing one divisor.
// One overflow stage then one quotient bit per stage. Depends on ptag_pkg.
module ptag_div #(
    parameter int NUM_W = ptag_pkg::COEF_W + ptag_pkg::COORD_BITS_DEF + 5
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [NUM_W-1:0]              num_x,
    input  logic [NUM_W-1:0]              num_y,
    input  logic [NUM_W-1:0]              den,
    input  ptag_pkg::ptag_side_t          side_in,
    output logic                          out_valid,
    output logic [ptag_pkg::QUO_BITS-1:0] q_x,
    output logic [ptag_pkg::QUO_BITS-1:0] q_y,
    output logic                          ovf_x,
    output logic                          ovf_y,
    output ptag_pkg::ptag_side_t          side_out
);
    import ptag_pkg::*;

    localparam int QB = QUO_BITS;
    localparam int NS = QB + 1;
    localparam int RW = NUM_W + QB + 1;

    logic              v_reg   [NS];
    logic [RW-1:0]     rx_reg  [NS];
    logic [RW-1:0]     ry_reg  [NS];
    logic [NUM_W-1:0]  d_reg   [NS];
    logic [QB-1:0]     qx_reg  [NS];
    logic [QB-1:0]     qy_reg  [NS];
    logic              ox_reg  [NS];
    logic              oy_reg  [NS];
    ptag_side_t        sd_reg  [NS];

    genvar s;
    generate
        for (s = 0; s < NS; s++)
        begin : g_stage
            logic [RW-1:0] rx_next, ry_next;
            logic [QB-1:0] qx_next, qy_next;
            logic          ox_next, oy_next;

            if (s == 0)
            begin : g_first
                logic [RW-1:0] lim;
                // quotient of 2^QB or more lands outside any source
                assign lim     = RW'(den) << QB;
                assign rx_next = RW'(num_x);
                assign ry_next = RW'(num_y);
                assign qx_next = '0;
                assign qy_next = '0;
                assign ox_next = (RW'(num_x) >= lim);
                assign oy_next = (RW'(num_y) >= lim);
            end
            else
            begin : g_bit
                logic [RW-1:0] t;
                logic          gx, gy;
                assign t  = RW'(d_reg[s-1]) << (QB - s);
                assign gx = (rx_reg[s-1] >= t);
                assign gy = (ry_reg[s-1] >= t);
                assign rx_next = gx ? rx_reg[s-1] - t : rx_reg[s-1];
                assign ry_next = gy ? ry_reg[s-1] - t : ry_reg[s-1];
                always_comb
                begin
                    qx_next = qx_reg[s-1];
                    qy_next = qy_reg[s-1];
                    qx_next[QB-s] = gx;
                    qy_next[QB-s] = gy;
                end
                assign ox_next = ox_reg[s-1];
                assign oy_next = oy_reg[s-1];
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[s] <= 1'b0;
                end
                else if (en)
                begin
                    v_reg[s] <= (s == 0) ? in_valid : v_reg[(s == 0) ? 0 : s-1];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rx_reg[s] <= rx_next;
                    ry_reg[s] <= ry_next;
                    qx_reg[s] <= qx_next;
                    qy_reg[s] <= qy_next;
                    ox_reg[s] <= ox_next;
                    oy_reg[s] <= oy_next;
                    d_reg[s]  <= (s == 0) ? den : d_reg[(s == 0) ? 0 : s-1];
                    sd_reg[s] <= (s == 0) ? side_in : sd_reg[(s == 0) ? 0 : s-1];
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[NS-1];
    assign q_x       = qx_reg[NS-1];
    assign q_y       = qy_reg[NS-1];
    assign ovf_x     = ox_reg[NS-1];
    assign ovf_y     = oy_reg[NS-1];
    assign side_out  = sd_reg[NS-1];

endmodule

/* design/ptag_check.sv */
// Back end: sign fix-up, source bounds and clip tests, read offset, output register.
// Two register stages. Depends on ptag_pkg and ptag_if.
module ptag_check #(
    parameter int COORD_BITS = ptag_pkg::COORD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  ptag_pkg::ptag_cfg_t           cfg,
    input  logic                          in_valid,
    input  logic [ptag_pkg::QUO_BITS-1:0] q_x,
    input  logic [ptag_pkg::QUO_BITS-1:0] q_y,
    input  logic                          ovf_x,
    input  logic                          ovf_y,
    input  ptag_pkg::ptag_side_t          side,
    ptag_out_if.source                    out_ch
);
    import ptag_pkg::*;

    localparam int CW = QUO_BITS + 2;

    logic              out_x, out_y, clipped;
    logic signed [CW-1:0] xs, ys, cx1, cx2, cy1, cy2;
    ptag_outcome_t     oc_next;

    logic              va_reg;
    ptag_outcome_t     oc_reg;
    logic [QUO_BITS-1:0] qx_reg, qy_reg;
    logic [OFF_W-1:0]  wr_reg;

    logic              vb_reg;
    logic [1:0]        outc_reg;
    logic [COORD_BITS-1:0] sx_reg, sy_reg;
    logic [OFF_W-1:0]  rd_reg, wo_reg;

    logic [2*DIM_W-1:0] rprod;
    logic [OFF_W-1:0]   rd_next;
    logic               keep;

    // negative quotient is only in range when it rounds to zero
    assign out_x = ovf_x | (side.neg_x & (|q_x)) | (q_x >= cfg.src_w);
    assign out_y = ovf_y | (side.neg_y & (|q_y)) | (q_y >= cfg.src_h);

    assign xs  = $signed(CW'({2'b00, q_x}));
    assign ys  = $signed(CW'({2'b00, q_y}));
    assign cx1 = CW'($signed(cfg.clip_x1));
    assign cx2 = CW'($signed(cfg.clip_x2));
    assign cy1 = CW'($signed(cfg.clip_y1));
    assign cy2 = CW'($signed(cfg.clip_y2));

    always_comb
    begin
        if (cfg.compressed)
        begin
            clipped = (xs >= cx2) || (xs < cx1) || (ys < cy1) || (ys >= cy2);
        end
        else
        begin
            clipped = (xs > cx2) || (xs < cx1) || (ys < cy1) || (ys > cy2);
        end
    end

    always_comb
    begin
        if (side.zero)
        begin
            oc_next = OUT_DEGEN;
        end
        else if (out_x || out_y)
        begin
            oc_next = OUT_OUTSIDE;
        end
        else if (cfg.clip_en && clipped)
        begin
            oc_next = OUT_CLIPPED;
        end
        else
        begin
            oc_next = OUT_WRITE;
        end
    end

    assign rprod   = qy_reg * cfg.src_w;
    assign rd_next = rprod[OFF_W-1:0] + OFF_W'(qx_reg);
    assign keep    = (oc_reg == OUT_WRITE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            oc_reg <= oc_next;
            qx_reg <= q_x;
            qy_reg <= q_y;
            wr_reg <= side.wr;

            outc_reg <= oc_reg;
            sx_reg   <= keep ? qx_reg[COORD_BITS-1:0] : '0;
            sy_reg   <= keep ? qy_reg[COORD_BITS-1:0] : '0;
            rd_reg   <= (keep && !cfg.solid) ? rd_next : '0;
            wo_reg   <= keep ? wr_reg : '0;
        end
    end

    assign out_ch.valid        = vb_reg;
    assign out_ch.outcome      = outc_reg;
    assign out_ch.src_x        = sx_reg;
    assign out_ch.src_y        = sy_reg;
    assign out_ch.read_offset  = rd_reg;
    assign out_ch.write_offset = wo_reg;

endmodule

/* design/projective_texture_address_gen_unit.sv */
// Projective texture address generator, top level.
// Pipeline: 3 transform, 17 divider and 2 check/output stages between input
// transaction and result. Throughput: one transaction per cycle; the whole
// pipeline holds when the output register is full and not taken.
// Reset: valid bits clear, coefficients return to identity, other config to 0.
// Depends on ptag_pkg, ptag_if, ptag_xform, ptag_div, ptag_check.
module projective_texture_address_gen_unit #(
    parameter int COORD_BITS = ptag_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = ptag_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    ptag_in_if.sink                           in_ch,
    ptag_out_if.source                        out_ch,
    input  logic                              cfg_we,
    input  logic [ptag_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ptag_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import ptag_pkg::*;

    localparam int NUM_W = COEF_W + COORD_BITS + 5;
    localparam logic [CFG_DATA_W-1:0] ONE_Q = CFG_DATA_W'(1) << FRAC_BITS;

    logic [63:0] coef_a_reg, coef_b_reg, coef_c_reg, coef_d_reg;
    logic [31:0] coef_l_reg, src_size_reg;
    logic [63:0] clip_reg;
    logic [50:0] canvas_reg;

    ptag_cfg_t   cfg;
    logic        en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_a_reg   <= ONE_Q;
            coef_b_reg   <= '0;
            coef_c_reg   <= ONE_Q;
            coef_d_reg   <= '0;
            coef_l_reg   <= ONE_Q[31:0];
            src_size_reg <= '0;
            clip_reg     <= '0;
            canvas_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_COEF_A:   coef_a_reg   <= cfg_data;
                CFG_COEF_B:   coef_b_reg   <= cfg_data;
                CFG_COEF_C:   coef_c_reg   <= cfg_data;
                CFG_COEF_D:   coef_d_reg   <= cfg_data;
                CFG_COEF_L:   coef_l_reg   <= cfg_data[31:0];
                CFG_SRC_SIZE: src_size_reg <= cfg_data[31:0];
                CFG_CLIP:     clip_reg     <= cfg_data;
                CFG_CANVAS:   canvas_reg   <= cfg_data[50:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        cfg.m00        = coef_a_reg[31:0];
        cfg.m01        = coef_a_reg[63:32];
        cfg.m02        = coef_b_reg[31:0];
        cfg.m10        = coef_b_reg[63:32];
        cfg.m11        = coef_c_reg[31:0];
        cfg.m12        = coef_c_reg[63:32];
        cfg.m20        = coef_d_reg[31:0];
        cfg.m21        = coef_d_reg[63:32];
        cfg.m22        = coef_l_reg;
        cfg.src_w      = src_size_reg[15:0];
        cfg.src_h      = src_size_reg[31:16];
        cfg.clip_x1    = clip_reg[15:0];
        cfg.clip_x2    = clip_reg[31:16];
        cfg.clip_y1    = clip_reg[47:32];
        cfg.clip_y2    = clip_reg[63:48];
        cfg.clip_en    = canvas_reg[50];
        cfg.solid      = canvas_reg[49];
        cfg.compressed = canvas_reg[48];
        cfg.canvas_w   = canvas_reg[47:32];
        cfg.sec_y1     = canvas_reg[31:16];
        cfg.sec_x1     = canvas_reg[15:0];
    end

    // single pipeline enable; the output register is the only place that can block
    assign en          = !out_ch.valid || out_ch.ready;
    assign in_ch.ready = en;

    logic             xf_valid;
    logic [NUM_W-1:0] num_x, num_y, den;
    ptag_side_t       xf_side;

    ptag_xform #(
        .COORD_BITS (COORD_BITS),
        .NUM_W      (NUM_W)
    ) u_xform (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .cfg       (cfg),
        .in_valid  (in_ch.valid),
        .in_x      (in_ch.dst_x),
        .in_y      (in_ch.dst_y),
        .out_valid (xf_valid),
        .num_x     (num_x),
        .num_y     (num_y),
        .den       (den),
        .side      (xf_side)
    );

    logic                dv_valid;
    logic [QUO_BITS-1:0] q_x, q_y;
    logic                ovf_x, ovf_y;
    ptag_side_t          dv_side;

    ptag_div #(
        .NUM_W (NUM_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (xf_valid),
        .num_x     (num_x),
        .num_y     (num_y),
        .den       (den),
        .side_in   (xf_side),
        .out_valid (dv_valid),
        .q_x       (q_x),
        .q_y       (q_y),
        .ovf_x     (ovf_x),
        .ovf_y     (ovf_y),
        .side_out  (dv_side)
    );

    ptag_check #(
        .COORD_BITS (COORD_BITS)
    ) u_check (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .cfg      (cfg),
        .in_valid (dv_valid),
        .q_x      (q_x),
        .q_y      (q_y),
        .ovf_x    (ovf_x),
        .ovf_y    (ovf_y),
        .side     (dv_side),
        .out_ch   (out_ch)
    );

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for projective_texture_address_gen_unit.
// Drives destination pixels under several register settings and checks each result
// against a local homography predictor. Depends on ptag_pkg, ptag_if and the RTL.
module tb_top;
    import ptag_pkg::*;

    localparam int CB = COORD_BITS_DEF;
    localparam int LAT = 22;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [CB-1:0] x;
        logic [CB-1:0] y;
    } pixel_t;

    typedef struct packed {
        ptag_outcome_t outcome;
        logic [CB-1:0] src_x;
        logic [CB-1:0] src_y;
        logic [OFF_W-1:0] rd;
        logic [OFF_W-1:0] wr;
    } texel_addr_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    ptag_in_if #(.COORD_BITS(CB)) in_ch();
    ptag_out_if #(.COORD_BITS(CB)) out_ch();

    projective_texture_address_gen_unit DUT (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // register shadow for the predictor
    logic [63:0] shadow [8];

    pixel_t      pixel_q [$];
    texel_addr_t addr_q  [$];
    int          errors = 0;
    bit          calm = 1'b0;
    bit          hold_off = 1'b0;
    int          idle_cnt = 0;

    function automatic longint sx32(logic [31:0] v);
        return longint'(signed'(v));
    endfunction

    function automatic longint sx16(logic [15:0] v);
        return longint'(signed'(v));
    endfunction

    function automatic longint round_div(longint num, longint den);
        bit neg;
        longint a;
        longint b;
        longint q;
        neg = (num < 0) != (den < 0);
        a = num < 0 ? -num : num;
        b = den < 0 ? -den : den;
        q = (2 * a + b) / (2 * b);
        return neg ? -q : q;
    endfunction

    function automatic texel_addr_t map_pixel(pixel_t p);
        texel_addr_t r;
        longint j, i, xn, yn, zn, sx, sy, w, h;
        longint cx1, cx2, cy1, cy2;
        logic [63:0] cc;
        logic [63:0] t;
        bit clipped;
        j = p.x;
        i = p.y;
        r = '0;
        cc = shadow[CFG_CANVAS];
        xn = sx32(shadow[CFG_COEF_A][31:0]) * j + sx32(shadow[CFG_COEF_A][63:32]) * i
           + sx32(shadow[CFG_COEF_B][31:0]);
        yn = sx32(shadow[CFG_COEF_B][63:32]) * j + sx32(shadow[CFG_COEF_C][31:0]) * i
           + sx32(shadow[CFG_COEF_C][63:32]);
        zn = sx32(shadow[CFG_COEF_D][31:0]) * j + sx32(shadow[CFG_COEF_D][63:32]) * i
           + sx32(shadow[CFG_COEF_L][31:0]);
        if (zn == 0)
        begin
            r.outcome = OUT_DEGEN;
            return r;
        end
        sx = round_div(xn, zn);
        sy = round_div(yn, zn);
        w = shadow[CFG_SRC_SIZE][15:0];
        h = shadow[CFG_SRC_SIZE][31:16];
        if (sx < 0 || sx >= w || sy < 0 || sy >= h)
        begin
            r.outcome = OUT_OUTSIDE;
            return r;
        end
        if (cc[50])
        begin
            cx1 = sx16(shadow[CFG_CLIP][15:0]);
            cx2 = sx16(shadow[CFG_CLIP][31:16]);
            cy1 = sx16(shadow[CFG_CLIP][47:32]);
            cy2 = sx16(shadow[CFG_CLIP][63:48]);
            if (cc[48])
                clipped = sx >= cx2 || sx < cx1 || sy < cy1 || sy >= cy2;
            else
                clipped = sx > cx2 || sx < cx1 || sy < cy1 || sy > cy2;
            if (clipped)
            begin
                r.outcome = OUT_CLIPPED;
                return r;
            end
        end
        r.outcome = OUT_WRITE;
        r.src_x = sx[CB-1:0];
        r.src_y = sy[CB-1:0];
        t = sy * w + sx;
        r.rd = cc[49] ? '0 : t[OFF_W-1:0];
        t = (i - longint'(cc[31:16])) * longint'(cc[47:32]) + j - longint'(cc[15:0]);
        r.wr = t[OFF_W-1:0];
        return r;
    endfunction

    // driver; the queue head is retired by the monitor at the accepting edge
    always @(negedge clk)
    begin
        if (pixel_q.size() > 0 && (calm || $urandom_range(99) >= 15))
        begin
            in_ch.valid <= 1'b1;
            in_ch.dst_x <= pixel_q[0].x;
            in_ch.dst_y <= pixel_q[0].y;
        end
        else
        begin
            in_ch.valid <= 1'b0;
            in_ch.dst_x <= CB'($urandom);
            in_ch.dst_y <= CB'($urandom);
        end
        out_ch.ready <= !hold_off && (calm || $urandom_range(99) >= 15);
    end

    // monitor: predict on input transactions, compare on output transactions
    always @(posedge clk)
    begin
        texel_addr_t got;
        texel_addr_t exp_a;
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            addr_q.push_back(map_pixel(pixel_t'({in_ch.dst_x, in_ch.dst_y})));
            void'(pixel_q.pop_front());
        end
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = {ptag_outcome_t'(out_ch.outcome), out_ch.src_x, out_ch.src_y,
                   out_ch.read_offset, out_ch.write_offset};
            if (addr_q.size() == 0)
            begin
                $error("unexpected result transaction");
                errors++;
            end
            else
            begin
                exp_a = addr_q.pop_front();
                if (got.outcome !== exp_a.outcome)
                begin
                    $error("outcome exp %0d got %0d", exp_a.outcome, got.outcome);
                    errors++;
                end
                if (got.src_x !== exp_a.src_x)
                begin
                    $error("src_x exp %0d got %0d", exp_a.src_x, got.src_x);
                    errors++;
                end
                if (got.src_y !== exp_a.src_y)
                begin
                    $error("src_y exp %0d got %0d", exp_a.src_y, got.src_y);
                    errors++;
                end
                if (got.rd !== exp_a.rd)
                begin
                    $error("read_offset exp %0d got %0d", exp_a.rd, got.rd);
                    errors++;
                end
                if (got.wr !== exp_a.wr)
                begin
                    $error("write_offset exp %0d got %0d", exp_a.wr, got.wr);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n
            || pixel_q.size() == 0 && addr_q.size() == 0 || hold_off)
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= WATCHDOG_LIMIT)
        begin
            $display("projective_texture_address_gen_unit verification failed");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_COEF_L, CFG_SRC_SIZE: shadow[idx] = {32'd0, val[31:0]};
            CFG_CANVAS: shadow[idx] = {13'd0, val[50:0]};
            default: shadow[idx] = val;
        endcase
    endtask

    task automatic drain();
        while (pixel_q.size() > 0 || addr_q.size() > 0)
            @(posedge clk);
        repeat (LAT + 4) @(posedge clk);
    endtask

    function automatic logic [63:0] q20(int v);
        return {32'd0, 32'(v <<< 20)};
    endfunction

    // identity-ish matrix with mild scale, shift and small projective terms; fully random when wild
    task automatic load_matrix(bit wild);
        logic [31:0] m [9];
        if (wild)
            foreach (m[k]) m[k] = $urandom;
        else
        begin
            m[0] = 32'h0008_0000 + $urandom_range(32'h0010_0000);
            m[1] = $urandom_range(32'h0004_0000) - 32'h0002_0000;
            m[2] = $urandom_range(32'h0800_0000) - 32'h0100_0000;
            m[3] = $urandom_range(32'h0004_0000) - 32'h0002_0000;
            m[4] = 32'h0008_0000 + $urandom_range(32'h0010_0000);
            m[5] = $urandom_range(32'h0800_0000) - 32'h0100_0000;
            m[6] = $urandom_range(64) - 32;
            m[7] = $urandom_range(64) - 32;
            m[8] = 32'h0010_0000 + $urandom_range(32'h0004_0000) - 32'h0002_0000;
        end
        write_reg(CFG_COEF_A, {m[1], m[0]});
        write_reg(CFG_COEF_B, {m[3], m[2]});
        write_reg(CFG_COEF_C, {m[5], m[4]});
        write_reg(CFG_COEF_D, {m[7], m[6]});
        write_reg(CFG_COEF_L, {32'd0, m[8]});
    endtask

    task automatic push_random(int n);
        pixel_t p;
        repeat (n)
        begin
            p.x = ($urandom_range(9) == 0) ? CB'($urandom) : CB'($urandom_range(700));
            p.y = ($urandom_range(9) == 0) ? CB'($urandom) : CB'($urandom_range(700));
            pixel_q.push_back(p);
        end
    endtask

    initial
    begin
        int ph;
        in_ch.valid = 1'b0;
        in_ch.dst_x = '0;
        in_ch.dst_y = '0;
        out_ch.ready = 1'b0;
        shadow[CFG_COEF_A] = 64'h0010_0000;
        shadow[CFG_COEF_B] = '0;
        shadow[CFG_COEF_C] = 64'h0010_0000;
        shadow[CFG_COEF_D] = '0;
        shadow[CFG_COEF_L] = 64'h0010_0000;
        shadow[CFG_SRC_SIZE] = '0;
        shadow[CFG_CLIP] = '0;
        shadow[CFG_CANVAS] = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // reset state: zero source size puts everything outside
        pixel_q.push_back('{x: 0, y: 0});
        pixel_q.push_back('{x: '1, y: '1});
        drain();

        // directed: identity, 4096 source, clip enabled plain mode
        write_reg(CFG_SRC_SIZE, {32'd0, 16'd4096, 16'd4096});
        write_reg(CFG_CLIP, {16'd3000, 16'hFFF0, 16'd3000, 16'd10});
        write_reg(CFG_CANVAS, {13'd0, 3'b100, 16'hFFFF, 16'd5, 16'd7});
        pixel_q.push_back('{x: 0, y: 0});
        pixel_q.push_back('{x: '1, y: '1});
        pixel_q.push_back('{x: 10, y: 3000});
        pixel_q.push_back('{x: 3000, y: 3000});
        pixel_q.push_back('{x: 3001, y: 5});
        pixel_q.push_back('{x: 9, y: 20});
        pixel_q.push_back('{x: 3, y: 2});
        drain();
        // compressed + solid: exclusive upper bound, zero read offset
        write_reg(CFG_CANVAS, {13'd0, 3'b111, 16'd640, 16'd0, 16'd0});
        pixel_q.push_back('{x: 3000, y: 100});
        pixel_q.push_back('{x: 2999, y: 2999});
        pixel_q.push_back('{x: 10, y: 10});
        drain();
        // half scale: rounding of .5 both signs; degenerate Z on a line
        write_reg(CFG_COEF_A, {32'd0, 32'h0008_0000});
        write_reg(CFG_COEF_B, {32'd0, 32'hFFF0_0000});
        write_reg(CFG_COEF_C, {32'd0, 32'h0008_0000});
        write_reg(CFG_COEF_D, {32'd0, 32'hFFF0_0000});
        write_reg(CFG_COEF_L, q20(5));
        write_reg(CFG_CANVAS, {13'd0, 3'b000, 16'd100, 16'd0, 16'd0});
        pixel_q.push_back('{x: 5, y: 1});
        pixel_q.push_back('{x: 4, y: 3});
        pixel_q.push_back('{x: 6, y: 7});
        pixel_q.push_back('{x: 7, y: 9});
        pixel_q.push_back('{x: 3, y: 0});
        drain();
        // extreme coefficients
        write_reg(CFG_COEF_A, 64'h8000_0000_7FFF_FFFF);
        write_reg(CFG_COEF_B, 64'h7FFF_FFFF_8000_0000);
        write_reg(CFG_COEF_C, 64'hFFFF_FFFF_0000_0001);
        write_reg(CFG_COEF_D, 64'h8000_0000_7FFF_FFFF);
        write_reg(CFG_COEF_L, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(CFG_SRC_SIZE, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(CFG_CLIP, 64'h7FFF_8000_7FFF_8000);
        write_reg(CFG_CANVAS, 64'hFFFF_FFFF_FFFF_FFFF);
        pixel_q.push_back('{x: 0, y: 0});
        pixel_q.push_back('{x: '1, y: 0});
        pixel_q.push_back('{x: 0, y: '1});
        pixel_q.push_back('{x: '1, y: '1});
        drain();

        // random phases
        for (ph = 0; ph < 12; ph++)
        begin
            load_matrix(ph % 5 == 4);
            write_reg(CFG_SRC_SIZE, {32'd0, 16'($urandom_range(1024)),
                                     16'($urandom_range(1024))});
            write_reg(CFG_CLIP, {16'($urandom_range(1100) - 50), 16'($urandom_range(500) - 50),
                                 16'($urandom_range(1100) - 50), 16'($urandom_range(500) - 50)});
            write_reg(CFG_CANVAS, {13'd0, 3'($urandom), 16'($urandom),
                                   16'($urandom_range(800)), 16'($urandom_range(800))});
            calm = (ph == 3);
            push_random(110);
            if (ph == 6)
            begin
                // long receiver stall while the sender keeps offering
                hold_off = 1'b1;
                repeat (200) @(posedge clk);
                hold_off = 1'b0;
            end
            drain();
        end
        calm = 1'b0;

        if (errors == 0)
            $display("projective_texture_address_gen_unit verification clean");
        else
            $display("projective_texture_address_gen_unit verification failed");
        $finish;
    end
endmodule

/* projective_texture_address_gen_unit.f */
design/ptag_pkg.sv
design/ptag_if.sv
design/ptag_xform.sv
design/ptag_div.sv
design/ptag_check.sv
design/projective_texture_address_gen_unit.sv
tb/tb_top.sv
